// ===== rtl/crc8rfp_pkg.sv =====
`timescale 1ns / 1ps

package crc8rfp_pkg;

  localparam int FrameLen = 4;
  localparam logic [7:0] StartChar = 8'h54;
  localparam logic [23:0] TickMax = 24'hFF_FFFF;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW = 24;
  localparam int RangeW = 15;
  localparam int SeqW = 32;
  localparam int TickW = 24;

  typedef enum logic [CfgIndexW-1:0] {
    REG_POLY     = 2'd0,
    REG_MIN      = 2'd1,
    REG_MAX      = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       tick_inc;
    logic       store;
    logic       crc_clear;
    logic       crc_step;
    logic [1:0] crc_idx;
    logic       restart;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_start;
    logic full;
    logic pass;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/crc8rfp_req_if.sv =====
`timescale 1ns / 1ps

interface crc8rfp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== rtl/crc8rfp_rsp_if.sv =====
`timescale 1ns / 1ps

interface crc8rfp_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] distance_mm;
  logic [31:0] seq_number;

  modport source (output valid, output distance_mm, output seq_number, input ready);
  modport sink (input valid, input distance_mm, input seq_number, output ready);
endinterface

// ===== rtl/crc8rfp_cfg_if.sv =====
`timescale 1ns / 1ps

interface crc8rfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crc8_range_frame_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Word
// req       in         req_type, data_byte (a received byte or one time tick)
// rsp       out        distance_mm, seq_number (one accepted reading)
// cfg       in         index, data (register write, always ready)
//
// A tick or a byte that does not close a full frame is handled in the cycle it is accepted.
// A start byte on a full frame is accepted, then the CRC unit folds the three stored
// bytes, one per cycle, then the frame is checked and, if it passes, the reading is
// emitted; a frame that fails the check is dropped. No request is accepted meanwhile.
// The emit waits while the previous reading is still held in the output register.
// Reset is synchronous; it sets the config and frame registers to defaults, not the CRC or output data.

module crc8_range_frame_parser_unit
  import crc8rfp_pkg::*;
(
  input logic           clk,
  input logic           rst,
  crc8rfp_req_if.sink   req,
  crc8rfp_rsp_if.source rsp,
  crc8rfp_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;

  assign req.ready = req_ready;

  crc8rfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  crc8rfp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_type  (req.req_type),
    .data_byte (req.data_byte),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/crc8rfp_ctrl.sv =====
`timescale 1ns / 1ps

module crc8rfp_ctrl
  import crc8rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] idx;
  logic       ready;
  logic       accept;
  logic       frame_close;

  assign req_ready = ready;
  assign accept = req_valid && ready && (state == S_IDLE);
  assign frame_close = !status.is_tick && status.is_start && status.full;

  always_comb begin
    cmd = '0;
    cmd.crc_idx = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.is_tick) begin
            cmd.tick_inc = 1'b1;
          end else if (!status.is_start && !status.full) begin
            cmd.store = 1'b1;
          end else if (frame_close) begin
            cmd.crc_clear = 1'b1;
          end else begin
            cmd.restart = 1'b1;
          end
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
      end
      S_CHECK: begin
        if (!status.pass) begin
          cmd.restart = 1'b1;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          cmd.restart = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= 2'd0;
      ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && frame_close) begin
            state <= S_CRC;
            idx <= 2'd0;
            ready <= 1'b0;
          end
        end
        S_CRC: begin
          if (idx == 2'd2) begin
            state <= S_CHECK;
          end
          idx <= idx + 2'd1;
        end
        S_CHECK: begin
          if (status.pass) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        S_EMIT: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/crc8rfp_dp.sv =====
`timescale 1ns / 1ps

module crc8rfp_dp
  import crc8rfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_type,
  input  logic [7:0]          data_byte,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  crc8rfp_cfg_if.sink         cfg,
  crc8rfp_rsp_if.source       rsp
);

  logic [7:0]        poly;
  logic [RangeW-1:0] range_lo;
  logic [RangeW-1:0] range_hi;
  logic [TickW-1:0]  interval;

  logic [7:0]        frame [FrameLen];
  logic [2:0]        fill;
  logic [7:0]        crc;
  logic [SeqW-1:0]   emitted;
  logic [TickW-1:0]  ticks;

  logic              out_valid;
  logic [RangeW-1:0] out_range;
  logic [SeqW-1:0]   out_seq;

  logic [15:0]       raw;
  logic              cfg_we;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] p);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ p) : (c << 1);
    end
    return c;
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;

  assign raw = {frame[1], frame[2]};

  assign status.is_tick = req_type;
  assign status.is_start = (data_byte == StartChar);
  assign status.full = (fill == 3'(FrameLen));
  assign status.pass = (crc == frame[3]) && !raw[15] &&
                       (raw[RangeW-1:0] > range_lo) && (raw[RangeW-1:0] < range_hi) &&
                       (ticks > interval);
  assign status.out_busy = out_valid && !rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.distance_mm = out_range;
  assign rsp.seq_number = out_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= 8'h07;
      range_lo <= RangeW'(200);
      range_hi <= RangeW'(14000);
      interval <= TickW'(1000);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg.index))
        REG_POLY:     poly <= cfg.data[7:0];
        REG_MIN:      range_lo <= cfg.data[RangeW-1:0];
        REG_MAX:      range_hi <= cfg.data[RangeW-1:0];
        REG_INTERVAL: interval <= cfg.data[TickW-1:0];
        default:      poly <= poly;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FrameLen; i++) begin
        frame[i] <= 8'h00;
      end
      fill <= 3'd0;
      emitted <= '0;
      ticks <= TickMax;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.tick_inc && (ticks != TickMax)) begin
        ticks <= ticks + TickW'(1);
      end
      if (cmd.store) begin
        frame[fill[1:0]] <= data_byte;
        fill <= fill + 3'd1;
      end
      if (cmd.restart) begin
        frame[0] <= StartChar;
        for (int i = 1; i < FrameLen; i++) begin
          frame[i] <= 8'h00;
        end
        fill <= 3'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        emitted <= emitted + SeqW'(1);
        ticks <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_clear) begin
      crc <= 8'h00;
    end else if (cmd.crc_step) begin
      crc <= crc8_byte(crc ^ frame[cmd.crc_idx], poly);
    end
    if (cmd.emit) begin
      out_range <= raw[RangeW-1:0];
      out_seq <= emitted;
    end
  end

endmodule
